>>> hdl/wvs_pkg.sv
`timescale 1ns / 1ps

package wvs_pkg;

  localparam int unsigned VERTEX_COUNT = 4096;
  localparam int unsigned VTX_AW = (VERTEX_COUNT > 1) ? $clog2(VERTEX_COUNT) : 1;
  localparam int unsigned MAT_ENTRIES = 12;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_ACCUM = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } opcode_e;

  typedef struct packed {
    opcode_e            opcode;
    logic [11:0]        target_index;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
    logic [16:0]        blend_weight;
  } req_t;

  typedef struct packed {
    logic signed [31:0] result_x;
    logic signed [31:0] result_y;
    logic signed [31:0] result_z;
    logic               saturated;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_FETCH,
    ST_CALC,
    ST_WRITEBACK,
    ST_RESP
  } state_e;

  // one row of the transform runs through these steps in order
  typedef enum logic [3:0] {
    MAC_IDLE,
    MAC_MUL_COORD,
    MAC_LOAD_MUL,
    MAC_ADD_MUL,
    MAC_ADD,
    MAC_BIAS,
    MAC_MUL_TLO,
    MAC_LOAD_MUL_THI,
    MAC_ADD_HI,
    MAC_CLAMP
  } mac_op_e;

  typedef struct packed {
    mac_op_e    op;
    logic [1:0] col;
  } mac_ctrl_t;

endpackage

>>> hdl/weighted_vertex_skinning.sv
`timescale 1ns / 1ps

// Channel   Ports                 Handshake
// request   req_i                 taken when start && !busy
// result    rsp_o, done_o         valid for one cycle while done_o is high
//
// Every request gives one result. Load and write go from acceptance through
// dispatch to the result strobe, read adds a fetch, and accumulate adds fetch,
// calc and writeback: one 33x33 multiplier is shared over three rows of nine
// steps each, plus a vertex store read and write.
// After reset the vertex store is zeroed one entry per cycle (all VERTEX_COUNT
// entries, 4096 here); busy stays high until that pass ends.
// Results cannot be held off; a new request is taken once busy drops.

module weighted_vertex_skinning (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  wvs_pkg::req_t req_i,
  output wvs_pkg::rsp_t rsp_o,
  output logic          done_o
);

  localparam int unsigned AW = wvs_pkg::VTX_AW;

  wvs_pkg::state_e   state_d, state_q;
  wvs_pkg::req_t     req_q;
  wvs_pkg::rsp_t     rsp_q;
  wvs_pkg::mac_op_e  phase_q;
  wvs_pkg::mac_ctrl_t mac_ctrl;

  logic signed [31:0] mat_q [wvs_pkg::MAT_ENTRIES];
  logic signed [31:0] vert_q [3];
  logic [1:0]         row_q;
  logic               sat_q;
  logic [AW-1:0]      clr_q;

  logic [95:0]        vtx_mem [wvs_pkg::VERTEX_COUNT];
  logic [95:0]        rd_q;
  logic               mem_we, mem_re;
  logic [AW-1:0]      mem_waddr;
  logic [95:0]        mem_wdata;
  logic [AW-1:0]      vtx_addr;
  logic               in_range;
  logic               clr_last;

  logic signed [31:0] mac_sum;
  logic               mac_sat;

  assign vtx_addr = AW'(req_q.target_index);
  assign in_range = 32'(req_q.target_index) < 32'(wvs_pkg::VERTEX_COUNT);
  assign clr_last = clr_q == AW'(wvs_pkg::VERTEX_COUNT - 1);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      wvs_pkg::ST_CLEAR: begin
        if (clr_last) state_d = wvs_pkg::ST_IDLE;
      end
      wvs_pkg::ST_IDLE: begin
        if (start) state_d = wvs_pkg::ST_DISPATCH;
      end
      wvs_pkg::ST_DISPATCH: begin
        if (in_range && (req_q.opcode == wvs_pkg::OP_ACCUM ||
                         req_q.opcode == wvs_pkg::OP_READ)) begin
          state_d = wvs_pkg::ST_FETCH;
        end else begin
          state_d = wvs_pkg::ST_RESP;
        end
      end
      wvs_pkg::ST_FETCH: begin
        if (req_q.opcode == wvs_pkg::OP_ACCUM) state_d = wvs_pkg::ST_CALC;
        else state_d = wvs_pkg::ST_RESP;
      end
      wvs_pkg::ST_CALC: begin
        if (phase_q == wvs_pkg::MAC_CLAMP && row_q == 2'd2) begin
          state_d = wvs_pkg::ST_WRITEBACK;
        end
      end
      wvs_pkg::ST_WRITEBACK: state_d = wvs_pkg::ST_RESP;
      wvs_pkg::ST_RESP:      state_d = wvs_pkg::ST_IDLE;
      default:               state_d = wvs_pkg::ST_IDLE;
    endcase
  end

  // outputs and store control
  always_comb begin
    busy      = state_q != wvs_pkg::ST_IDLE;
    done_o    = state_q == wvs_pkg::ST_RESP;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = vtx_addr;
    mem_wdata = {req_q.coord_z, req_q.coord_y, req_q.coord_x};
    unique case (state_q)
      wvs_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
      end
      wvs_pkg::ST_DISPATCH: begin
        mem_we = in_range && req_q.opcode == wvs_pkg::OP_WRITE;
        mem_re = in_range && (req_q.opcode == wvs_pkg::OP_ACCUM ||
                              req_q.opcode == wvs_pkg::OP_READ);
      end
      wvs_pkg::ST_WRITEBACK: begin
        mem_we    = 1'b1;
        mem_wdata = {vert_q[2], vert_q[1], vert_q[0]};
      end
      default: ;
    endcase
  end

  // column of the matrix row (and coordinate) each step works on
  always_comb begin
    mac_ctrl.op  = (state_q == wvs_pkg::ST_CALC) ? phase_q : wvs_pkg::MAC_IDLE;
    unique case (phase_q)
      wvs_pkg::MAC_LOAD_MUL: mac_ctrl.col = 2'd1;
      wvs_pkg::MAC_ADD_MUL:  mac_ctrl.col = 2'd2;
      wvs_pkg::MAC_BIAS:     mac_ctrl.col = 2'd3;
      default:               mac_ctrl.col = 2'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wvs_pkg::ST_CLEAR;
      clr_q   <= '0;
      phase_q <= wvs_pkg::MAC_IDLE;
      row_q   <= '0;
      // identity: diagonal entries are 1.0
      for (int i = 0; i < wvs_pkg::MAT_ENTRIES; i++) begin
        mat_q[i] <= (i == 0 || i == 5 || i == 10) ? 32'sh0001_0000 : '0;
      end
    end else begin
      state_q <= state_d;
      if (state_q == wvs_pkg::ST_CLEAR) clr_q <= clr_q + AW'(1);
      if (state_q == wvs_pkg::ST_DISPATCH && req_q.opcode == wvs_pkg::OP_LOAD &&
          req_q.target_index < 12'(wvs_pkg::MAT_ENTRIES)) begin
        mat_q[req_q.target_index[3:0]] <= req_q.coord_x;
      end
      if (state_q == wvs_pkg::ST_FETCH) begin
        phase_q <= wvs_pkg::MAC_MUL_COORD;
        row_q   <= '0;
      end else if (state_q == wvs_pkg::ST_CALC) begin
        unique case (phase_q)
          wvs_pkg::MAC_MUL_COORD:    phase_q <= wvs_pkg::MAC_LOAD_MUL;
          wvs_pkg::MAC_LOAD_MUL:     phase_q <= wvs_pkg::MAC_ADD_MUL;
          wvs_pkg::MAC_ADD_MUL:      phase_q <= wvs_pkg::MAC_ADD;
          wvs_pkg::MAC_ADD:          phase_q <= wvs_pkg::MAC_BIAS;
          wvs_pkg::MAC_BIAS:         phase_q <= wvs_pkg::MAC_MUL_TLO;
          wvs_pkg::MAC_MUL_TLO:      phase_q <= wvs_pkg::MAC_LOAD_MUL_THI;
          wvs_pkg::MAC_LOAD_MUL_THI: phase_q <= wvs_pkg::MAC_ADD_HI;
          wvs_pkg::MAC_ADD_HI:       phase_q <= wvs_pkg::MAC_CLAMP;
          wvs_pkg::MAC_CLAMP: begin
            phase_q <= wvs_pkg::MAC_MUL_COORD;
            row_q   <= row_q + 2'd1;
          end
          default:                   phase_q <= wvs_pkg::MAC_IDLE;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == wvs_pkg::ST_IDLE && start) req_q <= req_i;
    unique case (state_q)
      wvs_pkg::ST_DISPATCH: begin
        if (in_range && req_q.opcode == wvs_pkg::OP_WRITE) begin
          rsp_q.result_x  <= req_q.coord_x;
          rsp_q.result_y  <= req_q.coord_y;
          rsp_q.result_z  <= req_q.coord_z;
          rsp_q.saturated <= 1'b0;
        end else begin
          rsp_q <= '0;
        end
      end
      wvs_pkg::ST_FETCH: begin
        rsp_q.result_x  <= rd_q[31:0];
        rsp_q.result_y  <= rd_q[63:32];
        rsp_q.result_z  <= rd_q[95:64];
        rsp_q.saturated <= 1'b0;
        vert_q[0] <= rd_q[31:0];
        vert_q[1] <= rd_q[63:32];
        vert_q[2] <= rd_q[95:64];
        sat_q     <= 1'b0;
      end
      wvs_pkg::ST_CALC: begin
        if (phase_q == wvs_pkg::MAC_CLAMP) begin
          vert_q[row_q] <= mac_sum;
          sat_q         <= sat_q | mac_sat;
        end
      end
      wvs_pkg::ST_WRITEBACK: begin
        rsp_q.result_x  <= vert_q[0];
        rsp_q.result_y  <= vert_q[1];
        rsp_q.result_z  <= vert_q[2];
        rsp_q.saturated <= sat_q;
      end
      default: ;
    endcase
  end

  // vertex store
  always_ff @(posedge clk_i) begin
    if (mem_we) vtx_mem[mem_waddr] <= mem_wdata;
    if (mem_re) rd_q <= vtx_mem[vtx_addr];
  end

  assign rsp_o = rsp_q;

  wvs_mac u_mac (
    .clk_i     (clk_i),
    .ctrl_i    (mac_ctrl),
    .mat_i     (mat_q[{row_q, mac_ctrl.col}]),
    .coord_x_i (req_q.coord_x),
    .coord_y_i (req_q.coord_y),
    .coord_z_i (req_q.coord_z),
    .weight_i  (req_q.blend_weight),
    .stored_i  (vert_q[row_q]),
    .sum_o     (mac_sum),
    .sat_o     (mac_sat)
  );

endmodule

>>> hdl/wvs_mac.sv
`timescale 1ns / 1ps

module wvs_mac (
  input  logic               clk_i,
  input  wvs_pkg::mac_ctrl_t ctrl_i,
  input  logic signed [31:0] mat_i,
  input  logic signed [31:0] coord_x_i,
  input  logic signed [31:0] coord_y_i,
  input  logic signed [31:0] coord_z_i,
  input  logic [16:0]        weight_i,
  input  logic signed [31:0] stored_i,
  output logic signed [31:0] sum_o,
  output logic               sat_o
);

  localparam int unsigned MulW  = 33;
  localparam int unsigned ProdW = 2 * MulW;
  localparam int unsigned AccW  = 68;
  localparam int unsigned TW    = 50;

  localparam logic signed [AccW-1:0] VMax = AccW'(32'sh7FFF_FFFF);
  localparam logic signed [AccW-1:0] VMin = AccW'($signed(32'h8000_0000));

  logic signed [MulW-1:0]  mul_a;
  logic signed [MulW-1:0]  mul_b;
  logic signed [MulW-1:0]  w_ext;
  logic signed [31:0]      coord_sel;
  logic signed [ProdW-1:0] prod_d, prod_q;
  logic signed [AccW-1:0]  acc_q;
  logic signed [TW-1:0]    t_q;
  logic signed [AccW-1:0]  v_sum;

  assign w_ext = $signed({16'd0, weight_i});

  always_comb begin
    unique case (ctrl_i.col)
      2'd0:    coord_sel = coord_x_i;
      2'd1:    coord_sel = coord_y_i;
      2'd2:    coord_sel = coord_z_i;
      default: coord_sel = '0;
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (ctrl_i.op)
      wvs_pkg::MAC_MUL_COORD, wvs_pkg::MAC_LOAD_MUL, wvs_pkg::MAC_ADD_MUL: begin
        mul_a = MulW'(mat_i);
        mul_b = MulW'(coord_sel);
      end
      // t is split as t_hi * 2^32 + t_lo, t_lo unsigned
      wvs_pkg::MAC_MUL_TLO: begin
        mul_a = $signed({1'b0, t_q[31:0]});
        mul_b = w_ext;
      end
      wvs_pkg::MAC_LOAD_MUL_THI: begin
        mul_a = MulW'($signed(t_q[TW-1:32]));
        mul_b = w_ext;
      end
      default: ;
    endcase
  end

  assign prod_d = mul_a * mul_b;

  always_ff @(posedge clk_i) begin
    unique case (ctrl_i.op)
      wvs_pkg::MAC_MUL_COORD, wvs_pkg::MAC_MUL_TLO: begin
        prod_q <= prod_d;
      end
      wvs_pkg::MAC_LOAD_MUL, wvs_pkg::MAC_LOAD_MUL_THI: begin
        prod_q <= prod_d;
        acc_q  <= AccW'(prod_q);
      end
      wvs_pkg::MAC_ADD_MUL: begin
        prod_q <= prod_d;
        acc_q  <= acc_q + AccW'(prod_q);
      end
      wvs_pkg::MAC_ADD: begin
        acc_q <= acc_q + AccW'(prod_q);
      end
      wvs_pkg::MAC_BIAS: begin
        t_q <= TW'((acc_q >>> 16) + AccW'(mat_i));
      end
      wvs_pkg::MAC_ADD_HI: begin
        acc_q <= acc_q + (AccW'(prod_q) <<< 32);
      end
      default: ;
    endcase
  end

  // arithmetic shift gives floor division by 2^16
  assign v_sum = AccW'(stored_i) + (acc_q >>> 16);

  always_comb begin
    sat_o = 1'b0;
    sum_o = v_sum[31:0];
    if (v_sum > VMax) begin
      sat_o = 1'b1;
      sum_o = 32'sh7FFF_FFFF;
    end else if (v_sum < VMin) begin
      sat_o = 1'b1;
      sum_o = $signed(32'h8000_0000);
    end
  end

endmodule
